/* design/efr_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared types and codes for the front classifier, token queue and back tagger.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CMD_W  = 9;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_LEN    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_SHORT     = 2'd1,
        STAT_TRUNCATED = 2'd2,
        STAT_UNKNOWN   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_START   = 2'd0,
        REG_STOP    = 2'd1,
        REG_ESCAPE  = 2'd2,
        REG_CMD_CNT = 2'd3
    } reg_index_t;

    localparam logic [1:0] MIN_PAYLOAD = 2'd2;

    typedef struct packed {
        logic              is_stop;
        logic [BYTE_W-1:0] data;
    } token_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] stop_code;
        logic [BYTE_W-1:0] escape_code;
        logic [CMD_W-1:0]  command_count;
    } cfg_t;

endpackage

/* design/efr_front.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver front end
// Tracks framing and escapes, and turns raw bytes into payload and stop tokens.
// ----------------------------------------------------------------------------
module efr_front
    import efr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                accept,
    input  logic [BYTE_W-1:0]   rx_byte,
    output logic                tok_valid,
    output token_t              tok
);

    logic in_frame_reg, in_frame_next;
    logic esc_pending_reg, esc_pending_next;
    logic after_start_reg, after_start_next;
    logic is_start;
    logic bad_command;

    assign is_start    = (rx_byte == cfg.start_code);
    assign bad_command = ({1'b0, rx_byte} >= cfg.command_count);

    always_comb
    begin
        in_frame_next    = in_frame_reg;
        esc_pending_next = esc_pending_reg;
        after_start_next = after_start_reg;
        tok_valid        = 1'b0;
        tok.is_stop      = 1'b0;
        tok.data         = rx_byte;
        if (accept)
        begin
            if (in_frame_reg)
            begin
                if (esc_pending_reg)
                begin
                    esc_pending_next = 1'b0;
                    after_start_next = 1'b0;
                    tok_valid        = 1'b1;
                end
                else if (rx_byte == cfg.escape_code)
                begin
                    esc_pending_next = 1'b1;
                    after_start_next = 1'b0;
                end
                else if (rx_byte == cfg.stop_code)
                begin
                    in_frame_next    = 1'b0;
                    after_start_next = 1'b0;
                    tok_valid        = 1'b1;
                    tok.is_stop      = 1'b1;
                end
                else if (after_start_reg && bad_command)
                begin
                    // The rejected byte is looked at again as idle input.
                    in_frame_next    = is_start;
                    after_start_next = is_start;
                    esc_pending_next = 1'b0;
                end
                else
                begin
                    after_start_next = 1'b0;
                    tok_valid        = 1'b1;
                end
            end
            else if (is_start)
            begin
                in_frame_next    = 1'b1;
                after_start_next = 1'b1;
                esc_pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg    <= 1'b0;
            esc_pending_reg <= 1'b0;
            after_start_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg    <= in_frame_next;
            esc_pending_reg <= esc_pending_next;
            after_start_reg <= after_start_next;
        end
    end

endmodule

/* design/efr_fifo.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver token queue
// Short first-in first-out queue of tokens between the front and back ends.
// ----------------------------------------------------------------------------
module efr_fifo
    import efr_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  token_t wr_data,
    input  logic   rd_en,
    output token_t rd_data,
    output logic   full,
    output logic   not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    token_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/efr_back.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver back end
// Tags payload tokens by role, checks frame structure and holds the result.
// ----------------------------------------------------------------------------
module efr_back
    import efr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                tok_avail,
    input  token_t              tok,
    output logic                tok_take,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          item_kind,
    output logic [BYTE_W-1:0]   item_value,
    output logic [BYTE_W-1:0]   param_number,
    output logic [1:0]          frame_status,
    output logic                frame_last
);

    logic              out_valid_reg;
    logic [1:0]        kind_reg, kind_next;
    logic [BYTE_W-1:0] value_reg, value_next;
    logic [BYTE_W-1:0] pnum_reg, pnum_next;
    logic [1:0]        status_reg, status_next;
    logic              last_reg, last_next;

    logic [1:0]        pay_cnt_reg, pay_cnt_next;
    logic              unknown_reg, unknown_next;
    logic [BYTE_W-1:0] left_reg, left_next;
    logic [BYTE_W-1:0] pcnt_reg, pcnt_next;

    assign tok_take = tok_avail && (!out_valid_reg || pop);

    always_comb
    begin
        pay_cnt_next = pay_cnt_reg;
        unknown_next = unknown_reg;
        left_next    = left_reg;
        pcnt_next    = pcnt_reg;
        kind_next    = KIND_CMD;
        value_next   = tok.data;
        pnum_next    = '0;
        status_next  = STAT_OK;
        last_next    = 1'b0;
        if (tok.is_stop)
        begin
            kind_next  = KIND_END;
            value_next = '0;
            pnum_next  = pcnt_reg;
            last_next  = 1'b1;
            if (pay_cnt_reg < MIN_PAYLOAD)
            begin
                status_next = STAT_SHORT;
            end
            else if (unknown_reg)
            begin
                status_next = STAT_UNKNOWN;
            end
            else if (left_reg != '0)
            begin
                status_next = STAT_TRUNCATED;
            end
            // The next frame starts from a clean structure state.
            pay_cnt_next = '0;
            unknown_next = 1'b0;
            left_next    = '0;
            pcnt_next    = '0;
        end
        else
        begin
            if (pay_cnt_reg < MIN_PAYLOAD)
            begin
                pay_cnt_next = pay_cnt_reg + 1'b1;
            end
            if (pay_cnt_reg == 2'd0)
            begin
                unknown_next = ({1'b0, tok.data} >= cfg.command_count);
            end
            else if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
                kind_next = KIND_DATA;
                pnum_next = pcnt_reg;
            end
            else
            begin
                if (pay_cnt_reg != 2'd1 && pcnt_reg != '1)
                begin
                    pcnt_next = pcnt_reg + 1'b1;
                end
                left_next = tok.data;
                kind_next = KIND_LEN;
                pnum_next = pcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_take)
        begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            pnum_reg   <= pnum_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pay_cnt_reg   <= '0;
            unknown_reg   <= 1'b0;
            left_reg      <= '0;
            pcnt_reg      <= '0;
        end
        else
        begin
            if (tok_take)
            begin
                out_valid_reg <= 1'b1;
                pay_cnt_reg   <= pay_cnt_next;
                unknown_reg   <= unknown_next;
                left_reg      <= left_next;
                pcnt_reg      <= pcnt_next;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty        = !out_valid_reg;
    assign item_kind    = kind_reg;
    assign item_value   = value_reg;
    assign param_number = pnum_reg;
    assign frame_status = status_reg;
    assign frame_last   = last_reg;

`ifndef SYNTHESIS
    a_end_item_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (kind_reg == KIND_END && value_reg == '0))
        else $error("frame end item has wrong kind or non-zero value");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_END) |-> (status_reg == STAT_OK && !last_reg))
        else $error("status or last flag set on a payload item");

    a_count_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pay_cnt_reg <= MIN_PAYLOAD)
        else $error("payload count passed its saturation value");

    a_state_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_take && tok.is_stop) |=> (pay_cnt_reg == '0 && left_reg == '0 && pcnt_reg == '0))
        else $error("structure state not cleared after frame end");
`endif

endmodule

/* design/escaped_frame_receiver.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed frame receiver that tags payload bytes and checks frame layout.
// ----------------------------------------------------------------------------
// One raw byte is taken per clock cycle while full is low. The front end
// decides framing and escapes in the cycle that a byte is taken, and passes
// payload and stop tokens through a short token queue to the back end, which
// registers one result in the cycle after it takes a token. Results may be
// taken one per cycle; full rises only when the token queue (QUEUE_DEPTH
// entries) has filled because results are not being popped.
module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic                pop,
    output logic                empty,
    output logic [1:0]          item_kind,
    output logic [BYTE_W-1:0]   item_value,
    output logic [BYTE_W-1:0]   param_number,
    output logic [1:0]          frame_status,
    output logic                frame_last
);

    cfg_t       cfg_reg;
    reg_index_t reg_sel;
    logic       cfg_write;
    logic       accept;
    logic       tok_valid;
    token_t     front_tok;
    token_t     queue_tok;
    logic       queue_not_empty;
    logic       tok_take;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code    <= 8'd254;
            cfg_reg.stop_code     <= 8'd255;
            cfg_reg.escape_code   <= 8'd253;
            cfg_reg.command_count <= 9'd7;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_START:   cfg_reg.start_code    <= pwdata[BYTE_W-1:0];
                REG_STOP:    cfg_reg.stop_code     <= pwdata[BYTE_W-1:0];
                REG_ESCAPE:  cfg_reg.escape_code   <= pwdata[BYTE_W-1:0];
                REG_CMD_CNT: cfg_reg.command_count <= pwdata[CMD_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_START:   prdata = {24'd0, cfg_reg.start_code};
            REG_STOP:    prdata = {24'd0, cfg_reg.stop_code};
            REG_ESCAPE:  prdata = {24'd0, cfg_reg.escape_code};
            REG_CMD_CNT: prdata = {23'd0, cfg_reg.command_count};
            default:     prdata = '0;
        endcase
    end

    assign accept = push && !full;

    efr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .tok_valid (tok_valid),
        .tok       (front_tok)
    );

    efr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (tok_valid),
        .wr_data   (front_tok),
        .rd_en     (tok_take),
        .rd_data   (queue_tok),
        .full      (full),
        .not_empty (queue_not_empty)
    );

    efr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .tok_avail    (queue_not_empty),
        .tok          (queue_tok),
        .tok_take     (tok_take),
        .pop          (pop),
        .empty        (empty),
        .item_kind    (item_kind),
        .item_value   (item_value),
        .param_number (param_number),
        .frame_status (frame_status),
        .frame_last   (frame_last)
    );

endmodule
